/* design/kscd_pkg.sv */
// Shared types and constants for the keyboard scan-code decoder.
// No dependencies; used by kscd_front and keyboard_scancode_decoder_top.
package kscd_pkg;

    // Scan codes (set 1, make codes)
    localparam logic [7:0] CODE_EXTENDED = 8'd224;
    localparam logic [6:0] SC_LSHIFT     = 7'd42;
    localparam logic [6:0] SC_RSHIFT     = 7'd54;
    localparam logic [6:0] SC_LCTRL      = 7'd29;
    localparam logic [6:0] SC_LALT       = 7'd56;
    localparam logic [6:0] SC_STAR       = 7'd55;
    localparam logic [6:0] SC_F1         = 7'd59;
    localparam logic [6:0] SC_F2         = 7'd60;
    localparam logic [6:0] SC_F3         = 7'd61;
    localparam logic [6:0] SC_DEL        = 7'd83;
    localparam logic [6:0] SC_CAPS       = 7'd58;
    localparam logic [6:0] SC_NUM        = 7'd69;
    localparam logic [6:0] SC_SCROLL     = 7'd70;
    localparam logic [6:0] PAD_LOW       = 7'h47;
    localparam logic [6:0] PAD_HIGH      = 7'h53;

    // Modifier flag masks
    localparam logic [7:0] F_CAPS   = 8'h40;
    localparam logic [7:0] F_NUM    = 8'h20;
    localparam logic [7:0] F_SCROLL = 8'h10;
    localparam logic [7:0] F_ALT    = 8'h08;
    localparam logic [7:0] F_CTRL   = 8'h04;
    localparam logic [7:0] F_SHIFT  = 8'h03;

    // LED bit positions
    localparam int LED_SCROLL = 0;
    localparam int LED_NUM    = 1;
    localparam int LED_CAPS   = 2;

    // Keymap selects
    localparam logic [1:0] MAP_REGULAR = 2'd0;
    localparam logic [1:0] MAP_SHIFT   = 2'd1;
    localparam logic [1:0] MAP_CONTROL = 2'd2;
    localparam int         NUM_MAPS    = 3;

    // Event kinds
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_DOWN    = 4'd1;
    localparam logic [3:0] EV_UP      = 4'd2;
    localparam logic [3:0] EV_LED     = 4'd3;
    localparam logic [3:0] EV_REBOOT  = 4'd4;
    localparam logic [3:0] EV_SHOT    = 4'd5;
    localparam logic [3:0] EV_LOGIN   = 4'd6;
    localparam logic [3:0] EV_PROCS   = 4'd7;
    localparam logic [3:0] EV_WINDOWS = 4'd8;
    localparam logic [3:0] EV_MAPPED  = 4'd9;

    // Capslock translation
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // Decode stage result, waiting for the keymap read data
    typedef struct packed {
        logic [3:0] kind;
        logic       use_map;
        logic [1:0] map_sel;
        logic [7:0] flags;
        logic [2:0] leds;
    } t_s1;

endpackage

/* design/kscd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/kscd_front.sv */
// Decode stage: extended/modifier/LED state, event classification,
// keymap write and read addressing. Depends on kscd_pkg.
module kscd_front #(
    parameter int MAP_ENTRIES = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_operation,
    input  logic [7:0]                     i_scan_code,
    input  logic [1:0]                     i_map_select,
    input  logic [6:0]                     i_map_index,
    input  logic [7:0]                     i_map_byte,
    output logic [kscd_pkg::NUM_MAPS-1:0]  o_wr_en,
    output logic [$clog2(MAP_ENTRIES)-1:0] o_wr_addr,
    output logic [7:0]                     o_wr_data,
    output logic [$clog2(MAP_ENTRIES)-1:0] o_rd_addr,
    output kscd_pkg::t_s1                  o_s1
);

    localparam int AW = $clog2(MAP_ENTRIES);

    logic          r_ext;
    logic [7:0]    r_flags;
    logic [2:0]    r_leds;
    kscd_pkg::t_s1 r_s1;

    logic          n_ext;
    logic [7:0]    n_flags;
    logic [2:0]    n_leds;
    kscd_pkg::t_s1 n_s1;

    logic [6:0] code7;
    logic       release_key;
    logic       pad_key;

    assign code7       = i_scan_code[6:0];
    assign release_key = i_scan_code[7];
    assign pad_key     = (code7 >= kscd_pkg::PAD_LOW) && (code7 <= kscd_pkg::PAD_HIGH);

    always_comb begin
        n_ext        = r_ext;
        n_flags      = r_flags;
        n_leds       = r_leds;
        n_s1.kind    = kscd_pkg::EV_NONE;
        n_s1.use_map = 1'b0;
        n_s1.map_sel = kscd_pkg::MAP_REGULAR;
        o_wr_en      = '0;

        if (i_operation) begin
            case (i_map_select)
                kscd_pkg::MAP_REGULAR, kscd_pkg::MAP_SHIFT, kscd_pkg::MAP_CONTROL: begin
                    o_wr_en[i_map_select] = i_accept;
                    n_s1.kind             = kscd_pkg::EV_MAPPED;
                end
                default: begin
                    n_s1.kind = kscd_pkg::EV_NONE;
                end
            endcase
        end else if (i_scan_code == kscd_pkg::CODE_EXTENDED) begin
            n_ext = 1'b1;
        end else if (release_key && (code7 == kscd_pkg::SC_LSHIFT ||
                                     code7 == kscd_pkg::SC_RSHIFT)) begin
            n_flags = r_flags & ~kscd_pkg::F_SHIFT;
        end else if (release_key && code7 == kscd_pkg::SC_LCTRL) begin
            n_flags = r_flags & ~kscd_pkg::F_CTRL;
        end else if (release_key && code7 == kscd_pkg::SC_LALT) begin
            n_flags = r_flags & ~kscd_pkg::F_ALT;
        end else if (!release_key && (code7 == kscd_pkg::SC_LSHIFT ||
                                      code7 == kscd_pkg::SC_RSHIFT)) begin
            n_flags = r_flags | kscd_pkg::F_SHIFT;
        end else if (!release_key && code7 == kscd_pkg::SC_LCTRL) begin
            n_flags = r_flags | kscd_pkg::F_CTRL;
        end else if (!release_key && code7 == kscd_pkg::SC_LALT) begin
            n_flags = r_flags | kscd_pkg::F_ALT;
        end else if (!release_key && code7 == kscd_pkg::SC_CAPS) begin
            n_flags = r_flags ^ kscd_pkg::F_CAPS;
            n_leds[kscd_pkg::LED_CAPS] = |(n_flags & kscd_pkg::F_CAPS);
            n_s1.kind = kscd_pkg::EV_LED;
        end else if (!release_key && code7 == kscd_pkg::SC_NUM) begin
            n_flags = r_flags ^ kscd_pkg::F_NUM;
            n_leds[kscd_pkg::LED_NUM] = |(n_flags & kscd_pkg::F_NUM);
            n_s1.kind = kscd_pkg::EV_LED;
        end else if (!release_key && code7 == kscd_pkg::SC_SCROLL) begin
            n_flags = r_flags ^ kscd_pkg::F_SCROLL;
            n_leds[kscd_pkg::LED_SCROLL] = |(n_flags & kscd_pkg::F_SCROLL);
            n_s1.kind = kscd_pkg::EV_LED;
        end else if (!release_key && code7 == kscd_pkg::SC_F1) begin
            n_s1.kind = kscd_pkg::EV_LOGIN;
        end else if (!release_key && code7 == kscd_pkg::SC_F2) begin
            n_s1.kind = kscd_pkg::EV_PROCS;
        end else if (!release_key && code7 == kscd_pkg::SC_F3) begin
            n_s1.kind = kscd_pkg::EV_WINDOWS;
        end else if (code7 == 7'd0) begin
            // scan code zero: dropped
            n_s1.kind = kscd_pkg::EV_NONE;
        end else if (r_ext && code7 == kscd_pkg::SC_STAR && !release_key) begin
            n_ext     = 1'b0;
            n_s1.kind = kscd_pkg::EV_SHOT;
        end else if (!r_ext && ((|(r_flags & kscd_pkg::F_SHIFT)) ||
                                ((|(r_flags & kscd_pkg::F_NUM)) && pad_key))) begin
            n_ext        = 1'b0;
            n_s1.kind    = release_key ? kscd_pkg::EV_UP : kscd_pkg::EV_DOWN;
            n_s1.use_map = 1'b1;
            n_s1.map_sel = kscd_pkg::MAP_SHIFT;
        end else if (|(r_flags & kscd_pkg::F_CTRL)) begin
            if ((|(r_flags & kscd_pkg::F_ALT)) && code7 == kscd_pkg::SC_DEL && release_key) begin
                // ctrl-alt-del on release; extended flag kept
                n_s1.kind = kscd_pkg::EV_REBOOT;
            end else begin
                n_ext        = 1'b0;
                n_s1.kind    = release_key ? kscd_pkg::EV_UP : kscd_pkg::EV_DOWN;
                n_s1.use_map = 1'b1;
                n_s1.map_sel = kscd_pkg::MAP_CONTROL;
            end
        end else begin
            n_ext        = 1'b0;
            n_s1.kind    = release_key ? kscd_pkg::EV_UP : kscd_pkg::EV_DOWN;
            n_s1.use_map = 1'b1;
            n_s1.map_sel = kscd_pkg::MAP_REGULAR;
        end

        n_s1.flags = n_flags;
        n_s1.leds  = n_leds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext   <= 1'b0;
            r_flags <= '0;
            r_leds  <= '0;
        end else if (i_accept) begin
            r_ext   <= n_ext;
            r_flags <= n_flags;
            r_leds  <= n_leds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_wr_addr = AW'(i_map_index);
    assign o_wr_data = i_map_byte;
    assign o_rd_addr = AW'(code7 - 7'd1);
    assign o_s1      = r_s1;

endmodule

/* design/keyboard_scancode_decoder_top.sv */
// Keyboard scan-code set 1 decoder, top level.
// Pipeline: acceptance registers the decode result and keymap read; character select
// and capslock then feed the output register. One request per cycle while i_ready
// is high or the output is empty; the keymap RAM read port sets the two stages.
// Reset (i_rst_n low, synchronous) clears extended flag, modifier flags, LED bits
// and pipeline valids; keymaps are not cleared and read undefined until written.
module keyboard_scancode_decoder_top #(
    parameter int MAP_ENTRIES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_operation,
    input  logic [7:0] i_scan_code,
    input  logic [1:0] i_map_select,
    input  logic [6:0] i_map_index,
    input  logic [7:0] i_map_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_event_kind,
    output logic [7:0] o_char_code,
    output logic [2:0] o_led_bits,
    output logic [7:0] o_modifier_flags
);

    localparam int AW = $clog2(MAP_ENTRIES);

    logic                          accept;
    logic                          s1_adv;
    logic                          s2_free;
    logic                          r_s1_valid;
    logic                          r_out_valid;
    logic [kscd_pkg::NUM_MAPS-1:0] wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [7:0]                    wr_data;
    logic [AW-1:0]                 rd_addr;
    kscd_pkg::t_s1                 s1;
    logic [7:0]                    map_data [kscd_pkg::NUM_MAPS];
    logic [7:0]                    raw_char;
    logic [7:0]                    n_char;

    logic [3:0] r_kind;
    logic [7:0] r_char;
    logic [2:0] r_leds;
    logic [7:0] r_flags;

    // Two-stage pipe; each stage moves when the one after it is free or draining.
    assign s2_free = !r_out_valid || i_ready;
    assign s1_adv  = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;
    assign accept  = i_valid && o_ready;

    kscd_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_scan_code  (i_scan_code),
        .i_map_select (i_map_select),
        .i_map_index  (i_map_index),
        .i_map_byte   (i_map_byte),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .o_s1         (s1)
    );

    // One RAM per keymap; all three are read at the decoded index and character
    // select picks the one the decode stage chose. Read data holds while stage 1 stalls.
    for (genvar m = 0; m < kscd_pkg::NUM_MAPS; m++) begin : g_map
        kscd_ram #(
            .WIDTH (8),
            .DEPTH (MAP_ENTRIES)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[m]),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_data),
            .i_rd_en   (accept),
            .i_rd_addr (rd_addr),
            .o_rd_data (map_data[m])
        );
    end

    // Character select and capslock uppercasing
    always_comb begin
        case (s1.map_sel)
            kscd_pkg::MAP_SHIFT:   raw_char = map_data[kscd_pkg::MAP_SHIFT];
            kscd_pkg::MAP_CONTROL: raw_char = map_data[kscd_pkg::MAP_CONTROL];
            default:               raw_char = map_data[kscd_pkg::MAP_REGULAR];
        endcase
        if (!s1.use_map) begin
            n_char = 8'd0;
        end else if ((|(s1.flags & kscd_pkg::F_CAPS)) &&
                     raw_char >= kscd_pkg::CHAR_LOWER_A &&
                     raw_char <= kscd_pkg::CHAR_LOWER_Z) begin
            n_char = raw_char - kscd_pkg::CASE_OFFSET;
        end else begin
            n_char = raw_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_kind  <= s1.kind;
            r_char  <= n_char;
            r_leds  <= s1.leds;
            r_flags <= s1.flags;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_kind;
    assign o_char_code      = r_char;
    assign o_led_bits       = r_leds;
    assign o_modifier_flags = r_flags;

endmodule
